FILE: hw/rtl/bilinear_rgba_resampler_unit_assert.svh
// Assertion macros for the bilinear RGBA resampler.
// Included by the top level; expects clk and arst_n in scope.
`ifndef BILINEAR_RGBA_RESAMPLER_UNIT_ASSERT_SVH
`define BILINEAR_RGBA_RESAMPLER_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define BRR_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define BRR_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/brr_pkg.sv
// Shared constants, codes and stage payload types of the bilinear resampler.
// Depends on nothing; the interfaces and every RTL module but brr_ram import it.
`default_nettype none

package brr_pkg;

	localparam int unsigned MAX_SOURCE_WIDTH     = 256;
	localparam int unsigned MAX_SOURCE_HEIGHT    = 256;
	localparam int unsigned MAX_OUTPUT_DIMENSION = 4096;

	localparam int unsigned SRC_DIM_W   = 9;
	localparam int unsigned OUT_DIM_W   = 13;
	localparam int unsigned SRC_COORD_W = 8;
	localparam int unsigned OUT_COORD_W = 12;
	localparam int unsigned PIX_W       = 24;
	localparam int unsigned IN_PIX_W    = 32;
	localparam int unsigned CHAN_W      = 8;
	localparam int unsigned DEN_W       = OUT_DIM_W + 1;
	localparam int unsigned NUM_W       = 23;
	localparam int unsigned Q_W         = 8;
	localparam int unsigned HSUM_W      = 22;
	localparam int unsigned DSUM_W      = 2 * DEN_W - 1;
	localparam int unsigned ACC_W       = 35;
	localparam int unsigned BANK_DEPTH  = (MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT) / 4;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 13;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	typedef enum logic {
		FMT_RGBA = 1'b0,
		FMT_BGRA = 1'b1
	} fmt_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_BAD_CONFIG = 2'd1,
		STATUS_BAD_COORD  = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_WIDTH  = 3'd0,
		REG_SOURCE_HEIGHT = 3'd1,
		REG_OUTPUT_WIDTH  = 3'd2,
		REG_OUTPUT_HEIGHT = 3'd3,
		REG_SOURCE_FORMAT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [SRC_DIM_W-1:0] src_w;
		logic [SRC_DIM_W-1:0] src_h;
		logic [OUT_DIM_W-1:0] out_w;
		logic [OUT_DIM_W-1:0] out_h;
		fmt_t                 fmt;
	} cfg_t;

	typedef struct packed {
		cmd_t                   cmd;
		logic [SRC_COORD_W-1:0] sx;
		logic [SRC_COORD_W-1:0] sy;
		logic [PIX_W-1:0]       pix;
		logic [OUT_COORD_W-1:0] ox;
		logic [OUT_COORD_W-1:0] oy;
	} in_item_t;

	// One axis of the coordinate map: running remainder, clamp limit, quotient.
	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [NUM_W-1:0] lim;
		logic [Q_W-1:0]   quo;
	} axis_t;

	typedef struct packed {
		cmd_t                   cmd;
		logic [SRC_COORD_W-1:0] sx;
		logic [SRC_COORD_W-1:0] sy;
		logic [PIX_W-1:0]       pix;
		status_t                status;
		axis_t                  ax;
		axis_t                  ay;
	} front_t;

	// Neighbour parities and weights that travel beside the bank read data.
	typedef struct packed {
		cmd_t             cmd;
		status_t          status;
		logic             x0p;
		logic             x1p;
		logic             y0p;
		logic             y1p;
		logic [DEN_W-1:0] fx;
		logic [DEN_W-1:0] fy;
	} mem_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		status_t           status;
	} res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/brr_if.sv
// Channel interfaces of the bilinear resampler: input, result and configuration.
// Depends on brr_pkg for field widths.
`default_nettype none

interface brr_in_if import brr_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   command;
	logic [SRC_COORD_W-1:0] source_x;
	logic [SRC_COORD_W-1:0] source_y;
	logic [IN_PIX_W-1:0]    source_pixel;
	logic [OUT_COORD_W-1:0] output_x;
	logic [OUT_COORD_W-1:0] output_y;

	modport source (output valid, command, source_x, source_y, source_pixel, output_x,
		output_y, input ready);
	modport sink (input valid, command, source_x, source_y, source_pixel, output_x,
		output_y, output ready);
endinterface

interface brr_out_if import brr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic [CHAN_W-1:0] alpha;
	logic [1:0]        status;

	modport source (output valid, red, green, blue, alpha, status, input ready);
	modport sink (input valid, red, green, blue, alpha, status, output ready);
endinterface

interface brr_cfg_if import brr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/brr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module brr_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and read port; read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/brr_front.sv
// Coordinate front end: status check, source position numerators and the
// pipelined division that yields the lower neighbour and the fraction. Uses brr_pkg.
`default_nettype none

module brr_front import brr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     in_valid,
	input  in_item_t in_item,
	output logic     in_ready,
	output logic     out_valid,
	output front_t   out_item,
	input  logic     dn_en
);

	logic   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	front_t st_s1, st_s2, st_s3, st_s4, st_s5, st_s6;
	logic   en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	logic [DEN_W-1:0] den_x, den_y;
	logic [NUM_W-1:0] a_x, a_y, top_x, top_y;
	logic             bad_cfg, bad_coord;
	front_t           nx_s1, nx_s2;

	// One restoring division step at quotient bit b.
	function automatic axis_t div_step(axis_t a, logic [DEN_W-1:0] den, logic [2:0] b);
		logic [NUM_W-1:0] d;
		axis_t            r;
		r = a;
		d = NUM_W'(den) << b;
		if (r.num >= d) begin
			r.num    = r.num - d;
			r.quo[b] = 1'b1;
		end
		return r;
	endfunction

	// Two quotient bits per stage, starting at bit hb.
	function automatic front_t div_two(front_t f, logic [DEN_W-1:0] dx, logic [DEN_W-1:0] dy,
		logic [2:0] hb);
		front_t r;
		r    = f;
		r.ax = div_step(div_step(f.ax, dx, hb), dx, hb - 3'd1);
		r.ay = div_step(div_step(f.ay, dy, hb), dy, hb - 3'd1);
		return r;
	endfunction

	assign den_x = {cfg.out_w, 1'b0};
	assign den_y = {cfg.out_h, 1'b0};

	// Stage 1: validity, (2o+1)*src and the upper clamp (src-1)*2*out.
	always_comb begin
		bad_cfg = (cfg.src_w == '0) || (cfg.src_h == '0) || (cfg.out_w == '0) ||
			(cfg.out_h == '0) ||
			(cfg.src_w > SRC_DIM_W'(MAX_SOURCE_WIDTH)) ||
			(cfg.src_h > SRC_DIM_W'(MAX_SOURCE_HEIGHT)) ||
			(cfg.out_w > OUT_DIM_W'(MAX_OUTPUT_DIMENSION)) ||
			(cfg.out_h > OUT_DIM_W'(MAX_OUTPUT_DIMENSION));
		bad_coord = ({1'b0, in_item.ox} >= cfg.out_w) || ({1'b0, in_item.oy} >= cfg.out_h);
		a_x   = NUM_W'({in_item.ox, 1'b1}) * NUM_W'(cfg.src_w);
		a_y   = NUM_W'({in_item.oy, 1'b1}) * NUM_W'(cfg.src_h);
		top_x = NUM_W'(cfg.src_w - 9'd1) * NUM_W'(den_x);
		top_y = NUM_W'(cfg.src_h - 9'd1) * NUM_W'(den_y);

		nx_s1.cmd    = in_item.cmd;
		nx_s1.sx     = in_item.sx;
		nx_s1.sy     = in_item.sy;
		nx_s1.pix    = in_item.pix;
		nx_s1.ax     = '{num: a_x, lim: top_x, quo: '0};
		nx_s1.ay     = '{num: a_y, lim: top_y, quo: '0};
		if (bad_cfg) begin
			nx_s1.status = STATUS_BAD_CONFIG;
		end else if (bad_coord) begin
			nx_s1.status = STATUS_BAD_COORD;
		end else begin
			nx_s1.status = STATUS_OK;
		end
	end

	// Stage 2: subtract out, floor at zero and clamp to the last source index.
	always_comb begin
		nx_s2 = st_s1;
		if (st_s1.ax.num <= NUM_W'(cfg.out_w)) begin
			nx_s2.ax.num = '0;
		end else begin
			nx_s2.ax.num = st_s1.ax.num - NUM_W'(cfg.out_w);
		end
		if (nx_s2.ax.num > st_s1.ax.lim) begin
			nx_s2.ax.num = st_s1.ax.lim;
		end
		if (st_s1.ay.num <= NUM_W'(cfg.out_h)) begin
			nx_s2.ay.num = '0;
		end else begin
			nx_s2.ay.num = st_s1.ay.num - NUM_W'(cfg.out_h);
		end
		if (nx_s2.ay.num > st_s1.ay.lim) begin
			nx_s2.ay.num = st_s1.ay.lim;
		end
	end

	// Each stage moves when it is empty or the next one moves.
	assign en_s6    = !v_s6 || dn_en;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// Payload; stages 3 to 6 each resolve two quotient bits.
	always_ff @(posedge clk) begin
		if (en_s1) st_s1 <= nx_s1;
		if (en_s2) st_s2 <= nx_s2;
		if (en_s3) st_s3 <= div_two(st_s2, den_x, den_y, 3'd7);
		if (en_s4) st_s4 <= div_two(st_s3, den_x, den_y, 3'd5);
		if (en_s5) st_s5 <= div_two(st_s4, den_x, den_y, 3'd3);
		if (en_s6) st_s6 <= div_two(st_s5, den_x, den_y, 3'd1);
	end

	assign out_valid = v_s6;
	assign out_item  = st_s6;

endmodule

`default_nettype wire

FILE: hw/rtl/brr_store.sv
// Frame store split into four banks by column and row parity, so that the
// four neighbours are read in the same cycle. Uses brr_pkg and brr_ram.
`default_nettype none

module brr_store import brr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  up_valid,
	input  front_t                up_item,
	output logic                  up_en,
	output logic                  dn_valid,
	output mem_t                  dn_item,
	output logic [3:0][PIX_W-1:0] dn_px,
	input  logic                  dn_en
);

	localparam int unsigned BANK_AW = $clog2(BANK_DEPTH);

	logic                   v_s7;
	mem_t                   st_s7;
	logic                   en_s7;
	logic [SRC_COORD_W-1:0] lo_x, lo_y, hi_x, hi_y;
	logic [SRC_DIM_W-1:0]   lo_x_p1, lo_y_p1;
	logic                   do_write, do_read;
	logic [1:0]             wbank;
	logic [BANK_AW-1:0]     waddr;

	// Upper neighbour, clamped to the last column or row.
	always_comb begin
		lo_x    = up_item.ax.quo;
		lo_y    = up_item.ay.quo;
		lo_x_p1 = {1'b0, lo_x} + 9'd1;
		lo_y_p1 = {1'b0, lo_y} + 9'd1;
		hi_x    = (lo_x_p1 < cfg.src_w) ? lo_x_p1[SRC_COORD_W-1:0] :
			SRC_COORD_W'(cfg.src_w - 9'd1);
		hi_y    = (lo_y_p1 < cfg.src_h) ? lo_y_p1[SRC_COORD_W-1:0] :
			SRC_COORD_W'(cfg.src_h - 9'd1);
	end

	// A write item leaves this stage without waiting on the blend stages.
	assign en_s7    = !v_s7 || (st_s7.cmd == CMD_WRITE) || dn_en;
	assign up_en    = en_s7;
	assign do_write = up_valid && en_s7 && (up_item.cmd == CMD_WRITE);
	assign do_read  = up_valid && en_s7 && (up_item.cmd == CMD_SAMPLE);
	assign wbank    = {up_item.sy[0], up_item.sx[0]};
	assign waddr    = {up_item.sy[SRC_COORD_W-1:1], up_item.sx[SRC_COORD_W-1:1]};

	// Each bank reads whichever neighbour column and row have its parity.
	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic PX = ((b % 2) == 1);
		localparam logic PY = ((b / 2) == 1);
		logic [SRC_COORD_W-1:0] col, row;
		logic [BANK_AW-1:0]     raddr;

		assign col   = (lo_x[0] == PX) ? lo_x : hi_x;
		assign row   = (lo_y[0] == PY) ? lo_y : hi_y;
		assign raddr = {row[SRC_COORD_W-1:1], col[SRC_COORD_W-1:1]};

		brr_ram #(
			.WIDTH(PIX_W),
			.DEPTH(BANK_DEPTH)
		) u_bank (
			.clk   (clk),
			.we    (do_write && (wbank == 2'(b))),
			.waddr (waddr),
			.wdata (up_item.pix),
			.re    (do_read),
			.raddr (raddr),
			.rdata (dn_px[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en_s7) begin
			v_s7 <= up_valid;
		end
	end

	// Side information that lines up with the registered bank data.
	always_ff @(posedge clk) begin
		if (en_s7) begin
			st_s7.cmd    <= up_item.cmd;
			st_s7.status <= up_item.status;
			st_s7.x0p    <= lo_x[0];
			st_s7.x1p    <= hi_x[0];
			st_s7.y0p    <= lo_y[0];
			st_s7.y1p    <= hi_y[0];
			st_s7.fx     <= up_item.ax.num[DEN_W-1:0];
			st_s7.fy     <= up_item.ay.num[DEN_W-1:0];
		end
	end

	assign dn_valid = v_s7 && (st_s7.cmd == CMD_SAMPLE);
	assign dn_item  = st_s7;

endmodule

`default_nettype wire

FILE: hw/rtl/brr_blend.sv
// Weighted blend of the four neighbours and the pipelined rounding division
// by the weight total. Uses brr_pkg.
`default_nettype none

module brr_blend import brr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  up_valid,
	input  mem_t                  up_item,
	input  logic [3:0][PIX_W-1:0] up_px,
	output logic                  up_en,
	output logic                  dn_valid,
	output res_t                  dn_res,
	input  logic                  dn_ready
);

	typedef struct packed {
		status_t                 status;
		logic [2:0][HSUM_W-1:0]  top;
		logic [2:0][HSUM_W-1:0]  bot;
		logic [DEN_W-1:0]        wy0;
		logic [DEN_W-1:0]        wy1;
		logic [DSUM_W-1:0]       dsum;
	} hz_t;

	typedef struct packed {
		status_t                status;
		logic [2:0][ACC_W-1:0]  num;
		logic [2:0][Q_W-1:0]    quo;
		logic [DSUM_W-1:0]      dsum;
	} dv_t;

	logic v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;
	logic en_s8, en_s9, en_s10, en_s11, en_s12, en_s13;
	hz_t  st_s8, nx_s8;
	dv_t  st_s9, st_s10, st_s11, st_s12, st_s13, nx_s9;

	logic [DEN_W-1:0]             dx, dy, wx0;
	logic [2:0][CHAN_W-1:0]       c00, c10, c01, c11;

	// Channels in red, green, blue order for the configured byte order.
	function automatic logic [2:0][CHAN_W-1:0] order(logic [PIX_W-1:0] p, fmt_t f);
		logic [2:0][CHAN_W-1:0] r;
		r[1] = p[15:8];
		unique case (f)
			FMT_RGBA: begin
				r[0] = p[7:0];
				r[2] = p[23:16];
			end
			FMT_BGRA: begin
				r[0] = p[23:16];
				r[2] = p[7:0];
			end
			default: begin
				r[0] = p[7:0];
				r[2] = p[23:16];
			end
		endcase
		return r;
	endfunction

	// One restoring step at quotient bit b for all three channels.
	function automatic dv_t div_step(dv_t a, logic [2:0] b);
		logic [ACC_W-1:0] d;
		dv_t              r;
		r = a;
		d = ACC_W'(a.dsum) << b;
		for (int c = 0; c < 3; c++) begin
			if (r.num[c] >= d) begin
				r.num[c]    = r.num[c] - d;
				r.quo[c][b] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic dv_t div_two(dv_t a, logic [2:0] hb);
		return div_step(div_step(a, hb), hb - 3'd1);
	endfunction

	// Stage 8: horizontal interpolation of the upper and lower pairs.
	always_comb begin
		dx  = {cfg.out_w, 1'b0};
		dy  = {cfg.out_h, 1'b0};
		wx0 = dx - up_item.fx;
		c00 = order(up_px[{up_item.y0p, up_item.x0p}], cfg.fmt);
		c10 = order(up_px[{up_item.y0p, up_item.x1p}], cfg.fmt);
		c01 = order(up_px[{up_item.y1p, up_item.x0p}], cfg.fmt);
		c11 = order(up_px[{up_item.y1p, up_item.x1p}], cfg.fmt);
		nx_s8.status = up_item.status;
		nx_s8.wy0    = dy - up_item.fy;
		nx_s8.wy1    = up_item.fy;
		nx_s8.dsum   = DSUM_W'(dx) * DSUM_W'(dy);
		for (int c = 0; c < 3; c++) begin
			nx_s8.top[c] = HSUM_W'(c00[c]) * HSUM_W'(wx0) +
				HSUM_W'(c10[c]) * HSUM_W'(up_item.fx);
			nx_s8.bot[c] = HSUM_W'(c01[c]) * HSUM_W'(wx0) +
				HSUM_W'(c11[c]) * HSUM_W'(up_item.fx);
		end
	end

	// Stage 9: vertical interpolation plus half the total for rounding.
	always_comb begin
		nx_s9.status = st_s8.status;
		nx_s9.dsum   = st_s8.dsum;
		nx_s9.quo    = '0;
		for (int c = 0; c < 3; c++) begin
			nx_s9.num[c] = ACC_W'(st_s8.top[c]) * ACC_W'(st_s8.wy0) +
				ACC_W'(st_s8.bot[c]) * ACC_W'(st_s8.wy1) + ACC_W'(st_s8.dsum >> 1);
		end
	end

	// Stall chain back from the result register.
	assign en_s13 = !v_s13 || dn_ready;
	assign en_s12 = !v_s12 || en_s13;
	assign en_s11 = !v_s11 || en_s12;
	assign en_s10 = !v_s10 || en_s11;
	assign en_s9  = !v_s9 || en_s10;
	assign en_s8  = !v_s8 || en_s9;
	assign up_en  = en_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else begin
			if (en_s8)  v_s8  <= up_valid;
			if (en_s9)  v_s9  <= v_s8;
			if (en_s10) v_s10 <= v_s9;
			if (en_s11) v_s11 <= v_s10;
			if (en_s12) v_s12 <= v_s11;
			if (en_s13) v_s13 <= v_s12;
		end
	end

	// Stages 10 to 13 resolve two quotient bits each.
	always_ff @(posedge clk) begin
		if (en_s8)  st_s8  <= nx_s8;
		if (en_s9)  st_s9  <= nx_s9;
		if (en_s10) st_s10 <= div_two(st_s9, 3'd7);
		if (en_s11) st_s11 <= div_two(st_s10, 3'd5);
		if (en_s12) st_s12 <= div_two(st_s11, 3'd3);
		if (en_s13) st_s13 <= div_two(st_s12, 3'd1);
	end

	// Error results carry black.
	always_comb begin
		dn_res.status = st_s13.status;
		if (st_s13.status == STATUS_OK) begin
			dn_res.red   = st_s13.quo[0];
			dn_res.green = st_s13.quo[1];
			dn_res.blue  = st_s13.quo[2];
		end else begin
			dn_res.red   = '0;
			dn_res.green = '0;
			dn_res.blue  = '0;
		end
	end

	assign dn_valid = v_s13;

endmodule

`default_nettype wire

FILE: hw/rtl/bilinear_rgba_resampler_unit.sv
// Top level of the bilinear RGBA resampler: configuration registers and the
// front, store and blend pipeline. Uses brr_pkg, brr_if and the stage modules.
//
//   channel   dir   beat
//   in_ch     in    command, source_x/y, source_pixel, output_x/y
//   out_ch    out   red, green, blue, alpha, status (one per sample beat)
//   cfg_ch    in    index, data (register write, always ready)
//
// One beat enters per cycle while the pipeline is not stalled; a sample result passes
// through 13 register stages: two of setup, the two four-stage pipelined dividers,
// the bank read and the two blend stages.
// The frame store is four parity banks with a registered read and no clearing.
// Reset clears the registers and the valid bits only; a pixel beat writes its
// bank in stage 7, in order with the sample reads.
// A stalled output holds each full stage with no empty stage or stage-7 write item after it; empty stages still fill.
`default_nettype none
`include "bilinear_rgba_resampler_unit_assert.svh"

module bilinear_rgba_resampler_unit import brr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	brr_in_if.sink    in_ch,
	brr_out_if.source out_ch,
	brr_cfg_if.sink   cfg_ch
);

	cfg_t                  cfg_q;
	in_item_t              in_item;
	logic                  fr_valid, st_en, st_valid, bl_en;
	front_t                fr_item;
	mem_t                  st_item;
	logic [3:0][PIX_W-1:0] st_px;
	res_t                  res;

	// Configuration registers.
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{src_w: '0, src_h: '0, out_w: '0, out_h: '0, fmt: FMT_RGBA};
		end else if (cfg_ch.valid) begin
			unique case (reg_idx_t'(cfg_ch.index))
				REG_SOURCE_WIDTH:  cfg_q.src_w <= cfg_ch.data[SRC_DIM_W-1:0];
				REG_SOURCE_HEIGHT: cfg_q.src_h <= cfg_ch.data[SRC_DIM_W-1:0];
				REG_OUTPUT_WIDTH:  cfg_q.out_w <= cfg_ch.data;
				REG_OUTPUT_HEIGHT: cfg_q.out_h <= cfg_ch.data;
				REG_SOURCE_FORMAT: cfg_q.fmt   <= fmt_t'(cfg_ch.data[0]);
				default: begin
				end
			endcase
		end
	end

	// Input beat; the fourth source byte is dropped.
	assign in_item.cmd = cmd_t'(in_ch.command);
	assign in_item.sx  = in_ch.source_x;
	assign in_item.sy  = in_ch.source_y;
	assign in_item.pix = in_ch.source_pixel[PIX_W-1:0];
	assign in_item.ox  = in_ch.output_x;
	assign in_item.oy  = in_ch.output_y;

	brr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_ch.valid),
		.in_item   (in_item),
		.in_ready  (in_ch.ready),
		.out_valid (fr_valid),
		.out_item  (fr_item),
		.dn_en     (st_en)
	);

	brr_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (fr_valid),
		.up_item  (fr_item),
		.up_en    (st_en),
		.dn_valid (st_valid),
		.dn_item  (st_item),
		.dn_px    (st_px),
		.dn_en    (bl_en)
	);

	brr_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (st_valid),
		.up_item  (st_item),
		.up_px    (st_px),
		.up_en    (bl_en),
		.dn_valid (out_ch.valid),
		.dn_res   (res),
		.dn_ready (out_ch.ready)
	);

	// Result beat; alpha is always opaque.
	assign out_ch.red    = res.red;
	assign out_ch.green  = res.green;
	assign out_ch.blue   = res.blue;
	assign out_ch.alpha  = 8'hff;
	assign out_ch.status = res.status;

	// An error result is black.
	`BRR_ASSERT_IMPLY(a_error_black, out_ch.valid && (out_ch.status != STATUS_OK), (out_ch.red == 8'd0) && (out_ch.green == 8'd0) && (out_ch.blue == 8'd0), "error result with colour")
	// A ready output lets every stage move, so the input side must be ready.
	`BRR_ASSERT_IMPLY(a_ready_chain, out_ch.ready, in_ch.ready, "input stalled while output drains")

endmodule

`default_nettype wire

FILE: test/bilinear_rgba_resampler_unit_tb.sv
// Self-checking testbench of the bilinear RGBA resampler unit.
// Depends on brr_pkg, the brr_if channel interfaces and the unit itself.
`default_nettype none

module bilinear_rgba_resampler_unit_tb import brr_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		cmd_t        cmd;
		logic [7:0]  sx;
		logic [7:0]  sy;
		logic [31:0] pix;
		logic [11:0] ox;
		logic [11:0] oy;
	} beat_t;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		status_t    status;
	} pixel_t;

	localparam int DRAIN_CYCLES = 20;

	logic clk;
	logic arst_n;

	brr_in_if  in_ch ();
	brr_out_if out_ch ();
	brr_cfg_if cfg_ch ();

	bilinear_rgba_resampler_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// Copy of the frame store and the registers as the unit should hold them.
	logic [23:0] frame_copy [0:65535];
	int unsigned src_w, src_h, out_w, out_h;
	fmt_t        pix_fmt;

	beat_t  pending_beats [$];
	pixel_t expected_pixels [$];
	beat_t  next_beat;
	int     gap_pct;
	int     stall_pct;
	int     errors;

	// Clock generation.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Maps an output coordinate onto two source indices and a weight over 2*out.
	function automatic void map_axis(input int unsigned o, input int unsigned src,
		input int unsigned out, output int unsigned lo, output int unsigned hi,
		output longint unsigned frac);
		longint unsigned den;
		longint unsigned a;
		longint unsigned top;
		longint unsigned num;
		den = 2 * longint'(out);
		a = (2 * longint'(o) + 1) * src;
		top = longint'(src - 1) * den;
		num = (a <= out) ? 0 : a - out;
		if (num > top)
			num = top;
		lo = 32'(num / den);
		frac = num % den;
		hi = (lo + 1 < src) ? lo + 1 : src - 1;
	endfunction

	// Works out the pixel that a sample beat should produce.
	function automatic pixel_t predict_pixel(input int unsigned ox, input int unsigned oy);
		pixel_t          r;
		int unsigned     x0, x1, y0, y1;
		longint unsigned fx, fy, dx, dy, dsum, acc;
		longint unsigned wt [4];
		logic [23:0]     p [4];
		int              sh [3];
		logic [7:0]      ch [3];
		r.red = '0;
		r.green = '0;
		r.blue = '0;
		if (src_w == 0 || src_h == 0 || out_w == 0 || out_h == 0 ||
				src_w > MAX_SOURCE_WIDTH || src_h > MAX_SOURCE_HEIGHT ||
				out_w > MAX_OUTPUT_DIMENSION || out_h > MAX_OUTPUT_DIMENSION) begin
			r.status = STATUS_BAD_CONFIG;
			return r;
		end
		if (ox >= out_w || oy >= out_h) begin
			r.status = STATUS_BAD_COORD;
			return r;
		end
		map_axis(ox, src_w, out_w, x0, x1, fx);
		map_axis(oy, src_h, out_h, y0, y1, fy);
		dx = 2 * longint'(out_w);
		dy = 2 * longint'(out_h);
		p[0] = frame_copy[y0 * 256 + x0];
		p[1] = frame_copy[y0 * 256 + x1];
		p[2] = frame_copy[y1 * 256 + x0];
		p[3] = frame_copy[y1 * 256 + x1];
		wt[0] = (dx - fx) * (dy - fy);
		wt[1] = fx * (dy - fy);
		wt[2] = (dx - fx) * fy;
		wt[3] = fx * fy;
		dsum = dx * dy;
		if (pix_fmt == FMT_BGRA) begin
			sh = '{16, 8, 0};
		end else begin
			sh = '{0, 8, 16};
		end
		for (int c = 0; c < 3; c++) begin
			acc = 0;
			for (int k = 0; k < 4; k++)
				acc += longint'((p[k] >> sh[c]) & 8'hff) * wt[k];
			acc = (acc + dsum / 2) / dsum;
			ch[c] = (acc > 255) ? 8'hff : acc[7:0];
		end
		r.red = ch[0];
		r.green = ch[1];
		r.blue = ch[2];
		r.status = STATUS_OK;
		return r;
	endfunction

	// Driver: on each accepted beat update the store copy or queue the expected
	// pixel, then offer the next pending beat unless a gap is drawn.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.command <= 1'b0;
			in_ch.source_x <= '0;
			in_ch.source_y <= '0;
			in_ch.source_pixel <= '0;
			in_ch.output_x <= '0;
			in_ch.output_y <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.command == CMD_WRITE)
					frame_copy[{in_ch.source_y, in_ch.source_x}] = in_ch.source_pixel[23:0];
				else
					expected_pixels.push_back(predict_pixel(in_ch.output_x, in_ch.output_y));
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_beats.size() > 0 && $urandom_range(99) >= gap_pct) begin
					next_beat = pending_beats.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.command <= next_beat.cmd;
					in_ch.source_x <= next_beat.sx;
					in_ch.source_y <= next_beat.sy;
					in_ch.source_pixel <= next_beat.pix;
					in_ch.output_x <= next_beat.ox;
					in_ch.output_y <= next_beat.oy;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result beat with the oldest expected pixel.
	always @(posedge clk or negedge arst_n) begin
		pixel_t exp_px;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected result beat");
					errors++;
				end else begin
					exp_px = expected_pixels.pop_front();
					if (out_ch.red !== exp_px.red) begin
						$error("red: expected %0d, got %0d", exp_px.red, out_ch.red);
						errors++;
					end
					if (out_ch.green !== exp_px.green) begin
						$error("green: expected %0d, got %0d", exp_px.green, out_ch.green);
						errors++;
					end
					if (out_ch.blue !== exp_px.blue) begin
						$error("blue: expected %0d, got %0d", exp_px.blue, out_ch.blue);
						errors++;
					end
					if (out_ch.alpha !== 8'hff) begin
						$error("alpha: expected 255, got %0d", out_ch.alpha);
						errors++;
					end
					if (out_ch.status !== exp_px.status) begin
						$error("status: expected %0d, got %0d", exp_px.status, out_ch.status);
						errors++;
					end
				end
			end
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic void push_write(input int unsigned x, input int unsigned y,
		input logic [31:0] pix);
		beat_t b;
		b.cmd = CMD_WRITE;
		b.sx = 8'(x);
		b.sy = 8'(y);
		b.pix = pix;
		b.ox = 12'($urandom);
		b.oy = 12'($urandom);
		pending_beats.push_back(b);
	endfunction

	function automatic void push_sample(input int unsigned x, input int unsigned y);
		beat_t b;
		b.cmd = CMD_SAMPLE;
		b.sx = 8'($urandom);
		b.sy = 8'($urandom);
		b.pix = $urandom;
		b.ox = 12'(x);
		b.oy = 12'(y);
		pending_beats.push_back(b);
	endfunction

	// Writes every pixel of the configured source area so no sample reads an
	// entry that was never written.
	function automatic void fill_source();
		for (int y = 0; y < src_h; y++)
			for (int x = 0; x < src_w; x++)
				push_write(x, y, $urandom);
	endfunction

	// Random mix: mostly in-range samples, some out-of-range ones and writes.
	function automatic void push_random(input int count);
		bit ok;
		ok = src_w >= 1 && src_w <= 256 && src_h >= 1 && src_h <= 256 &&
			out_w >= 1 && out_w <= 4096 && out_h >= 1 && out_h <= 4096;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0, 1: begin
					if (ok && $urandom_range(1))
						push_write($urandom_range(src_w - 1), $urandom_range(src_h - 1),
							$urandom);
					else if (ok)
						push_write($urandom_range(255), $urandom_range(255), $urandom);
					else
						push_sample($urandom_range(4095), $urandom_range(4095));
				end
				2, 3: push_sample($urandom_range(4095), $urandom_range(4095));
				default: begin
					if (ok)
						push_sample($urandom_range(out_w - 1), $urandom_range(out_h - 1));
					else
						push_sample($urandom_range(4095), $urandom_range(4095));
				end
			endcase
		end
	endfunction

	// Waits until every beat is sent and every result has come, then lets the
	// pipeline settle so that trailing pixel writes land.
	task automatic drain();
		do
			@(posedge clk);
		while (pending_beats.size() > 0 || in_ch.valid || expected_pixels.size() > 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input int unsigned val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= CFG_DATA_W'(val);
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			REG_SOURCE_WIDTH:  src_w = val & 9'h1ff;
			REG_SOURCE_HEIGHT: src_h = val & 9'h1ff;
			REG_OUTPUT_WIDTH:  out_w = val & 13'h1fff;
			REG_OUTPUT_HEIGHT: out_h = val & 13'h1fff;
			default:           pix_fmt = fmt_t'(val[0]);
		endcase
	endtask

	// Programs all registers between phases while the unit is idle.
	task automatic configure(input int unsigned sw, input int unsigned sh,
		input int unsigned ow, input int unsigned oh, input int unsigned fmt);
		write_reg(REG_SOURCE_WIDTH, sw);
		write_reg(REG_SOURCE_HEIGHT, sh);
		write_reg(REG_OUTPUT_WIDTH, ow);
		write_reg(REG_OUTPUT_HEIGHT, oh);
		write_reg(REG_SOURCE_FORMAT, fmt);
		cfg_ch.valid <= 1'b0;
	endtask

	// One phase: new settings, a fresh source area if the source size is valid, random beats, full drain.
	task automatic run_phase(input int unsigned sw, input int unsigned sh,
		input int unsigned ow, input int unsigned oh, input int unsigned fmt,
		input int count, input int mode);
		case (mode % 4)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 54; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 54; end
			default: begin gap_pct = 8; stall_pct = 8; end
		endcase
		configure(sw, sh, ow, oh, fmt);
		if (sw >= 1 && sw <= 256 && sh >= 1 && sh <= 256)
			fill_source();
		push_random(count);
		drain();
	endtask

	// Stimulus sequence.
	initial begin
		errors = 0;
		gap_pct = 0;
		stall_pct = 0;
		src_w = 0;
		src_h = 0;
		out_w = 0;
		out_h = 0;
		pix_fmt = FMT_RGBA;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Registers straight out of reset: every sample reports a bad setting.
		push_sample(0, 0);
		push_sample(4095, 4095);
		push_write(255, 255, 32'hffff_ffff);
		drain();

		// Directed: 2x2 upscale to 4x4 with known corner values.
		configure(2, 2, 4, 4, FMT_RGBA);
		push_write(0, 0, 32'h0000_0000);
		push_write(1, 0, 32'hffff_ffff);
		push_write(0, 1, 32'h00ff_00ff);
		push_write(1, 1, 32'hff00_ff00);
		push_sample(0, 0);
		push_sample(3, 3);
		push_sample(1, 2);
		push_sample(2, 1);
		push_sample(4, 0);
		push_sample(0, 4);
		push_sample(4095, 4095);
		drain();

		// Same pixels read in the swapped byte order.
		configure(2, 2, 4, 4, FMT_BGRA);
		push_sample(1, 1);
		push_sample(3, 0);
		drain();

		// Invalid settings: a zero size in each register in turn.
		configure(0, 2, 4, 4, FMT_RGBA);
		push_sample(0, 0);
		drain();
		configure(2, 0, 4, 4, FMT_RGBA);
		push_sample(0, 0);
		drain();
		configure(2, 2, 0, 4, FMT_RGBA);
		push_sample(0, 0);
		drain();
		configure(2, 2, 4, 0, FMT_RGBA);
		push_sample(0, 0);
		drain();

		// Random phases across the range of settings, extremes among them.
		run_phase(4, 4, 8, 8, 0, 30, 0);
		run_phase(256, 1, 4096, 1, 1, 30, 1);
		run_phase(1, 24, 1, 4096, 0, 30, 2);
		run_phase(1, 1, 1, 1, 1, 15, 3);
		run_phase(511, 5, 8191, 8191, 1, 10, 0);
		run_phase(257, 257, 4097, 4097, 0, 10, 1);
		run_phase(8, 6, 3, 2, 1, 20, 2);
		run_phase(5, 3, 13, 9, 0, 20, 3);
		for (int i = 0; i < 4; i++)
			run_phase($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 40),
				$urandom_range(1, 40), $urandom_range(1), 10, i);

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Run limit.
	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
